FILE: src/sadc_pkg.sv
package sadc_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CHANNELS_DEF    = 8;

	// channel level registers, fixed by the register map
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 12;
	localparam int CFG_IDX_W = 4;
	localparam int CMD_BITS  = 4;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_CMD,
		PH_DATA,
		PH_DONE
	} phase_t;

endpackage

FILE: src/sadc_req_if.sv
interface sadc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic       select_pin;
	logic [7:0] mosi_byte;

	modport source (output valid, output req_type, output select_pin, output mosi_byte,
		input ready);
	modport sink (input valid, input req_type, input select_pin, input mosi_byte,
		output ready);
endinterface

FILE: src/sadc_rsp_if.sv
interface sadc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] miso_byte;

	modport source (output valid, output miso_byte, input ready);
	modport sink (input valid, input miso_byte, output ready);
endinterface

FILE: src/spi_adc_slave_readout_core.sv
// Serial side of an SPI converter with up to eight channels of SAMPLE_BITS each.
// req channel: one transaction is a chip-select pin event (req_type 0, select_pin
// 0 = selected) or one master byte (req_type 1, mosi_byte MSB first).
// rsp channel: one miso_byte for each byte that arrives while selected; pin
// events and bytes while deselected give nothing.
// Config port: cfg_we/cfg_index/cfg_data write channel level registers 0..7,
// clamped to the sample range; other indexes are dropped. Write only while idle.
// A request is captured in the input stage, then all eight bit steps of the byte
// resolve combinationally into the output register, which drives the reply.
// Throughput is one transaction per cycle unless a byte meets a stalled rsp, set by
// the combinational bit-step logic between input stage and output register.
// A stalled rsp holds the output register; the input stage keeps accepting
// pin events and deselected bytes, and stalls only when a byte would need the
// busy output slot.
// Reset clears all levels, deselects, and puts the transfer back to waiting
// for a start bit; both channels come out of reset empty.
module spi_adc_slave_readout_core #(
	parameter int SAMPLE_BITS = sadc_pkg::SAMPLE_BITS_DEF,
	parameter int CHANNELS    = sadc_pkg::CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sadc_req_if.sink                       req,
	sadc_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [sadc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sadc_pkg::REG_W-1:0]     cfg_data
);

	localparam int REPLY_LEN = SAMPLE_BITS + 1;
	localparam int RPOS_W    = $clog2(REPLY_LEN + 1);
	localparam int MAX_W     = (SAMPLE_BITS > sadc_pkg::REG_W) ? SAMPLE_BITS : sadc_pkg::REG_W;
	localparam logic [MAX_W-1:0] LEVEL_MAX = MAX_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [sadc_pkg::REG_W-1:0] levels_q [sadc_pkg::NUM_REGS];

	sadc_pkg::phase_t phase_q, phase_d;
	logic                 sel_q, sel_d;
	logic [3:0]           cmd_q, cmd_d;
	logic [2:0]           cnt_q, cnt_d;
	logic [REPLY_LEN-1:0] reply_q, reply_d;
	logic [RPOS_W-1:0]    pos_q, pos_d;

	logic       valid_s1;
	logic       req_type_s1;
	logic       select_pin_s1;
	logic [7:0] mosi_byte_s1;

	logic       out_valid_q;
	logic [7:0] miso_byte_s2;

	logic       produce;
	logic [7:0] dout;
	logic       out_free;
	logic       fire_s1;

	// config writes, clamped to the sample range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sadc_pkg::NUM_REGS; i++) begin
				levels_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < sadc_pkg::CFG_IDX_W'(sadc_pkg::NUM_REGS))) begin
			if (MAX_W'(cfg_data) > LEVEL_MAX) begin
				levels_q[cfg_index[2:0]] <= sadc_pkg::REG_W'(LEVEL_MAX);
			end else begin
				levels_q[cfg_index[2:0]] <= cfg_data;
			end
		end
	end

	assign out_free  = !out_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && (!produce || out_free);
	assign req.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1   <= req.req_type;
			select_pin_s1 <= req.select_pin;
			mosi_byte_s1  <= req.mosi_byte;
		end
	end

	// pin events and the eight bit steps of one byte
	always_comb begin
		sadc_pkg::phase_t     ph;
		logic [3:0]           cs;
		logic [2:0]           cnt;
		logic [REPLY_LEN-1:0] rb;
		logic [RPOS_W-1:0]    rp;
		logic [MAX_W-1:0]     wide;
		logic                 b;
		ph      = phase_q;
		cs      = cmd_q;
		cnt     = cnt_q;
		rb      = reply_q;
		rp      = pos_q;
		wide    = '0;
		b       = 1'b0;
		dout    = '0;
		sel_d   = sel_q;
		produce = 1'b0;
		if (!req_type_s1) begin
			if (!select_pin_s1 && !sel_q) begin
				ph    = sadc_pkg::PH_WAIT;
				cs    = '0;
				cnt   = '0;
				rb    = '0;
				rp    = '0;
				sel_d = 1'b1;
			end else if (select_pin_s1 && sel_q) begin
				sel_d = 1'b0;
			end
		end else if (sel_q) begin
			produce = 1'b1;
			for (int i = 7; i >= 0; i--) begin
				b = mosi_byte_s1[i];
				case (ph)
					sadc_pkg::PH_WAIT: begin
						if (b) begin
							ph  = sadc_pkg::PH_CMD;
							cs  = '0;
							cnt = '0;
						end
					end
					sadc_pkg::PH_CMD: begin
						cs  = {cs[2:0], b};
						cnt = cnt + 3'd1;
						if (cnt >= 3'(sadc_pkg::CMD_BITS)) begin
							wide = MAX_W'(levels_q[cs[2:0]]);
							if ({1'b0, cs[2:0]} < 4'(CHANNELS)) begin
								rb = {1'b0, wide[SAMPLE_BITS-1:0]};
							end else begin
								rb = '0;
							end
							rp = '0;
							ph = sadc_pkg::PH_DATA;
						end
					end
					sadc_pkg::PH_DATA: begin
						// null bit first: it is the zero MSB of the reply word
						dout[i] = rb[REPLY_LEN-1];
						rb      = {rb[REPLY_LEN-2:0], 1'b0};
						rp      = rp + 1'b1;
						if (rp == RPOS_W'(REPLY_LEN)) begin
							ph = sadc_pkg::PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
		phase_d = ph;
		cmd_d   = cs;
		cnt_d   = cnt;
		reply_d = rb;
		pos_d   = rp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sadc_pkg::PH_WAIT;
			sel_q   <= 1'b0;
			cmd_q   <= '0;
			cnt_q   <= '0;
			reply_q <= '0;
			pos_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			sel_q   <= sel_d;
			cmd_q   <= cmd_d;
			cnt_q   <= cnt_d;
			reply_q <= reply_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && produce) begin
			miso_byte_s2 <= dout;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.miso_byte = miso_byte_s2;

`ifndef SYNTH
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sadc_pkg::PH_DONE |-> pos_q == RPOS_W'(REPLY_LEN))
		else $error("reply finished with wrong bit count");

	a_cmd_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sadc_pkg::PH_CMD |-> cnt_q < 3'(sadc_pkg::CMD_BITS))
		else $error("command phase overran its bit count");

	a_reply_selected: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(sel_q))
		else $error("reply issued for a byte while deselected");
`endif

endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVEL_MAX      = (1 << sadc_pkg::SAMPLE_BITS_DEF) - 1;
	localparam int REPLY_LEN      = sadc_pkg::SAMPLE_BITS_DEF + 1;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 8;
	localparam int SETTLE_CYCLES  = 4;

	localparam bit REQ_PIN     = 1'b0;
	localparam bit REQ_BYTE    = 1'b1;
	localparam bit PIN_SELECT  = 1'b0;
	localparam bit PIN_RELEASE = 1'b1;

	typedef enum {LV_MIXED, LV_ZERO, LV_MAX, LV_RANDOM, LV_CHECKER} level_mode_t;

	// Tracks the converter's serial state and the miso bytes it must return.
	class sadc_scoreboard;
		logic [sadc_pkg::REG_W-1:0]    level [sadc_pkg::NUM_REGS];
		sadc_pkg::phase_t              ph;
		bit                            sel;
		logic [sadc_pkg::CMD_BITS-1:0] cmd;
		int unsigned                   cmd_cnt;
		logic [REPLY_LEN-1:0]          reply;
		int unsigned                   pos;
		logic [7:0]                    miso_q [$];
		int unsigned                   mismatches;
		int unsigned                   active_items;

		function new();
			foreach (level[i])
				level[i] = '0;
			sel = 1'b0;
			mismatches = 0;
			active_items = 0;
			restart();
		endfunction

		function void restart();
			ph = sadc_pkg::PH_WAIT;
			cmd = '0;
			cmd_cnt = 0;
			reply = '0;
			pos = 0;
		endfunction

		function void write_level(int unsigned idx, logic [sadc_pkg::REG_W-1:0] v);
			if (idx < sadc_pkg::NUM_REGS)
				level[idx] = (v > LEVEL_MAX) ? LEVEL_MAX[sadc_pkg::REG_W-1:0] : v;
		endfunction

		function bit shift_bit(bit din);
			bit dout;
			logic [2:0] ch;
			dout = 1'b0;
			case (ph)
			sadc_pkg::PH_WAIT: begin
				if (din) begin
					ph = sadc_pkg::PH_CMD;
					cmd = '0;
					cmd_cnt = 0;
				end
			end
			sadc_pkg::PH_CMD: begin
				cmd = {cmd[sadc_pkg::CMD_BITS-2:0], din};
				cmd_cnt++;
				if (cmd_cnt >= sadc_pkg::CMD_BITS) begin
					// level latched here; later writes leave this transfer alone
					ch = cmd[2:0];
					reply = (ch < sadc_pkg::CHANNELS_DEF) ? REPLY_LEN'(level[ch]) : '0;
					pos = 0;
					ph = sadc_pkg::PH_DATA;
				end
			end
			sadc_pkg::PH_DATA: begin
				// null bit is the zero MSB of reply
				dout = reply[REPLY_LEN-1-pos];
				pos++;
				if (pos >= REPLY_LEN)
					ph = sadc_pkg::PH_DONE;
			end
			default: ;
			endcase
			return dout;
		endfunction

		function void note_request(bit rtype, bit pin, logic [7:0] mosi);
			logic [7:0] miso;
			if (rtype == REQ_PIN) begin
				if (pin == PIN_SELECT && !sel) begin
					restart();
					sel = 1'b1;
					active_items++;
				end else if (pin == PIN_RELEASE && sel) begin
					sel = 1'b0;
					active_items++;
				end
			end else if (sel) begin
				miso = '0;
				for (int i = 7; i >= 0; i--)
					miso = {miso[6:0], shift_bit(mosi[i])};
				miso_q.push_back(miso);
				active_items++;
			end
		endfunction

		function void check_reply(logic [7:0] got);
			logic [7:0] want;
			if (miso_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected miso transaction: got %02h", got);
			end else begin
				want = miso_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("miso mismatch: expected %02h, got %02h", want, got);
				end
			end
		endfunction

		function int pending();
			return miso_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [sadc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sadc_pkg::REG_W-1:0]     cfg_data;
	bit                             calm = 1'b0;
	bit                             idle_on = 1'b1;

	sadc_scoreboard sb = new();

	sadc_req_if req_ch ();
	sadc_rsp_if rsp_ch ();

	spi_adc_slave_readout_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_req(input bit rtype, input bit pin, input logic [7:0] mosi);
		if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= rtype;
		req_ch.select_pin <= pin;
		req_ch.mosi_byte  <= mosi;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(rtype, pin, mosi);
	endtask

	// always waits on the clock before returning so valid is never lowered and raised in one step
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic logic [sadc_pkg::REG_W-1:0] level_for(level_mode_t mode, int i);
		logic [sadc_pkg::REG_W-1:0] mixed [sadc_pkg::NUM_REGS] = '{12'h000, 12'hFFF,
			12'h800, 12'h001, 12'h555, 12'hAAA, 12'h7FF, 12'h9C3};
		case (mode)
		LV_MIXED:   return mixed[i];
		LV_ZERO:    return '0;
		LV_MAX:     return LEVEL_MAX[sadc_pkg::REG_W-1:0];
		LV_CHECKER: return (i % 2) ? 12'h555 : 12'hAAA;
		default:    return sadc_pkg::REG_W'($urandom);
		endcase
	endfunction

	task automatic load_levels(input level_mode_t mode);
		logic [sadc_pkg::REG_W-1:0] v;
		int idx;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = 0; i < sadc_pkg::NUM_REGS; i++) begin
			v = level_for(mode, i);
			cfg_we    <= 1'b1;
			cfg_index <= sadc_pkg::CFG_IDX_W'(i);
			cfg_data  <= v;
			@(posedge clk);
			sb.write_level(i, v);
		end
		// indexes past the map must be dropped
		repeat ($urandom_range(1, 2)) begin
			v = sadc_pkg::REG_W'($urandom);
			idx = $urandom_range(sadc_pkg::NUM_REGS, 2**sadc_pkg::CFG_IDX_W - 1);
			cfg_we    <= 1'b1;
			cfg_index <= sadc_pkg::CFG_IDX_W'(idx);
			cfg_data  <= v;
			@(posedge clk);
			sb.write_level(idx, v);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic directed_items();
		send_req(REQ_BYTE, PIN_SELECT, 8'hFF);   // byte while deselected
		send_req(REQ_PIN, PIN_RELEASE, 8'h00);   // deselect while deselected
		send_req(REQ_PIN, PIN_SELECT, 8'hFF);
		send_req(REQ_PIN, PIN_SELECT, 8'h00);    // select while selected
		send_req(REQ_BYTE, PIN_RELEASE, 8'h00);  // zeros before start bit
		send_req(REQ_BYTE, PIN_SELECT, 8'h06);
		send_req(REQ_BYTE, PIN_SELECT, 8'h40);   // channel 1, full scale
		send_req(REQ_BYTE, PIN_SELECT, 8'h00);
		send_req(REQ_BYTE, PIN_SELECT, 8'h00);
		send_req(REQ_BYTE, PIN_SELECT, 8'hFF);   // past the reply: zeros
		send_req(REQ_PIN, PIN_RELEASE, 8'hFF);
		send_req(REQ_BYTE, PIN_RELEASE, 8'hAA);
		send_req(REQ_PIN, PIN_RELEASE, 8'h00);
		send_req(REQ_PIN, PIN_SELECT, 8'h00);
		send_req(REQ_BYTE, PIN_RELEASE, 8'hFF);  // start at MSB, channel 7
		send_req(REQ_BYTE, PIN_RELEASE, 8'hFF);
		send_req(REQ_PIN, PIN_RELEASE, 8'h00);   // deselect mid reply
		send_req(REQ_PIN, PIN_SELECT, 8'h00);
		send_req(REQ_BYTE, PIN_SELECT, 8'h01);   // start at LSB
		send_req(REQ_BYTE, PIN_SELECT, 8'h30);   // channel 3
		send_req(REQ_BYTE, PIN_SELECT, 8'h00);
		send_req(REQ_BYTE, PIN_SELECT, 8'h00);
		send_req(REQ_BYTE, PIN_SELECT, 8'h0F);   // reply done: start bits ignored
		send_req(REQ_BYTE, PIN_SELECT, 8'hFF);
		send_req(REQ_PIN, PIN_RELEASE, 8'h00);
	endtask

	// one read frame: leading zeros, start bit, command, then enough clocks for the reply unless cut short
	task automatic run_frame();
		logic [95:0] stream;
		int lead;
		int nbytes;
		stream = {$urandom, $urandom, $urandom};
		lead = $urandom_range(0, 15);
		for (int p = 0; p < lead; p++)
			stream[95-p] = 1'b0;
		stream[95-lead] = 1'b1;
		nbytes = (lead + 1 + sadc_pkg::CMD_BITS + REPLY_LEN + $urandom_range(0, 10) + 7) / 8;
		send_req(REQ_PIN, PIN_SELECT, 8'($urandom));
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 39) == 0)
				break;
			send_req(REQ_BYTE, 1'($urandom), stream[95-8*i -: 8]);
		end
		if ($urandom_range(0, 3) != 0)
			send_req(REQ_PIN, PIN_RELEASE, 8'($urandom));
	endtask

	task automatic run_segment(input int unsigned quota);
		int unsigned start;
		start = sb.active_items;
		while (sb.active_items - start < quota) begin
			if ($urandom_range(0, 19) == 0)
				idle_on = !idle_on;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4))
					send_req(1'($urandom), 1'($urandom), 8'($urandom));
			end else begin
				run_frame();
			end
			if ($urandom_range(0, 59) == 0)
				drain();
		end
	endtask

	initial begin
		level_mode_t modes [5] = '{LV_ZERO, LV_MAX, LV_RANDOM, LV_CHECKER, LV_RANDOM};
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_PIN;
		req_ch.select_pin <= PIN_RELEASE;
		req_ch.mosi_byte  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_levels(LV_MIXED);
		directed_items();
		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 5)
				calm = 1'b1;
			run_segment(305);
			if (seg < 5)
				load_levels(modes[seg]);
		end
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int stall_left;
		bit stall_on;
		stall_left = 0;
		stall_on = 1'b1;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				sb.check_reply(rsp_ch.miso_byte);
			if ($urandom_range(0, 63) == 0)
				stall_on = !stall_on;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && stall_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
src/sadc_pkg.sv
src/sadc_req_if.sv
src/sadc_rsp_if.sv
src/spi_adc_slave_readout_core.sv
tb/tb.sv
